// ===== rtl/c420ds_pkg.sv =====
package c420ds_pkg;

   localparam int MAX_WIDTH  = 2048;
   localparam int MAX_HEIGHT = 2048;

   localparam int SAMPLE_W = 8;
   localparam int PAIR_W   = SAMPLE_W + 1;
   localparam int BLK_W    = 8;
   localparam int CSR_IDX_W = 4;

   // Raster counters and effective sizes (size needs one bit more than the counter)
   localparam int COL_W    = $clog2(MAX_WIDTH);
   localparam int ROW_W    = $clog2(MAX_HEIGHT);
   localparam int WSIZE_W  = COL_W + 1;
   localparam int HSIZE_W  = ROW_W + 1;

   localparam int LINE_DEPTH = MAX_WIDTH / 2;
   localparam int SLOT_W     = COL_W - 1;

   localparam int MAX_WBLK = MAX_WIDTH / 16;
   localparam int MAX_HBLK = MAX_HEIGHT / 16;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = CSR_IDX_W'(1);

   // Raster position as seen by the lanes
   typedef struct packed {
      logic              col_odd;
      logic              row_odd;
      logic [SLOT_W-1:0] slot;
      logic              row_end;
      logic              frame_end;
   } pos_type;

   // Per-cycle lane controls
   typedef struct packed {
      logic              take;     // request accepted this cycle
      logic              col_odd;
      logic              row_odd;
      logic [SLOT_W-1:0] slot;
      logic              load;     // stage 1 moves to the output register
      logic              restart;
   } lane_ctl_type;

endpackage

// ===== rtl/c420ds_ctrl.sv =====
module c420ds_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                take,
   input  logic                                csr_wr,
   input  logic [c420ds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [c420ds_pkg::BLK_W-1:0]        csr_data,
   output c420ds_pkg::pos_type                 pos
);

   localparam int COL_W   = c420ds_pkg::COL_W;
   localparam int ROW_W   = c420ds_pkg::ROW_W;
   localparam int WSIZE_W = c420ds_pkg::WSIZE_W;
   localparam int HSIZE_W = c420ds_pkg::HSIZE_W;
   localparam int WCMP_W  = (WSIZE_W > c420ds_pkg::BLK_W + 1) ? WSIZE_W : c420ds_pkg::BLK_W + 1;
   localparam int HCMP_W  = (HSIZE_W > c420ds_pkg::BLK_W + 1) ? HSIZE_W : c420ds_pkg::BLK_W + 1;

   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [WSIZE_W-1:0] width_ff, width_in;
   logic [HSIZE_W-1:0] height_ff, height_in;

   logic [WCMP_W-1:0]  wblk;
   logic [HCMP_W-1:0]  hblk;
   logic               row_end, frame_end;

   // Block count: zero acts as one, large values clamp to the largest size that fits
   always_comb begin
      wblk = (csr_data == '0) ? WCMP_W'(1) : WCMP_W'(csr_data);
      if (wblk > WCMP_W'(c420ds_pkg::MAX_WBLK)) begin
         wblk = WCMP_W'(c420ds_pkg::MAX_WBLK);
      end
      hblk = (csr_data == '0) ? HCMP_W'(1) : HCMP_W'(csr_data);
      if (hblk > HCMP_W'(c420ds_pkg::MAX_HBLK)) begin
         hblk = HCMP_W'(c420ds_pkg::MAX_HBLK);
      end
   end

   assign row_end   = ({1'b0, col_ff} + WSIZE_W'(1)) >= width_ff;
   assign frame_end = row_end && (({1'b0, row_ff} + HSIZE_W'(1)) >= height_ff);

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      col_in    = col_ff;
      row_in    = row_ff;
      if (csr_wr) begin
         col_in = '0;
         row_in = '0;
         if (csr_index == c420ds_pkg::CSR_WIDTH) begin
            width_in = WSIZE_W'(wblk << 4);
         end else if (csr_index == c420ds_pkg::CSR_HEIGHT) begin
            height_in = HSIZE_W'(hblk << 4);
         end else begin
            col_in = col_ff;
            row_in = row_ff;
         end
      end else if (take) begin
         if (frame_end) begin
            col_in = '0;
            row_in = '0;
         end else if (row_end) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         row_ff    <= '0;
         width_ff  <= WSIZE_W'(16);
         height_ff <= HSIZE_W'(16);
      end else begin
         col_ff    <= col_in;
         row_ff    <= row_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign pos.col_odd   = col_ff[0];
   assign pos.row_odd   = row_ff[0];
   assign pos.slot      = col_ff[COL_W-1:1];
   assign pos.row_end   = row_end;
   assign pos.frame_end = frame_end;

endmodule

// ===== rtl/c420ds_lane.sv =====
module c420ds_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  c420ds_pkg::lane_ctl_type            ctl,
   input  logic [c420ds_pkg::SAMPLE_W-1:0]     sample,
   output logic [c420ds_pkg::SAMPLE_W-1:0]     average
);

   localparam int PAIR_W = c420ds_pkg::PAIR_W;
   localparam int SUM_W  = PAIR_W + 2;

   // Pair sums of the even row, one entry per column pair
   logic [PAIR_W-1:0] line_mem [c420ds_pkg::LINE_DEPTH];

   logic [PAIR_W-1:0]   pair_ff, pair_in;
   logic [PAIR_W-1:0]   above_ff;
   logic [PAIR_W-1:0]   below_ff;
   logic [c420ds_pkg::SAMPLE_W-1:0] avg_ff;
   logic [SUM_W-1:0]    total;

   assign pair_in = ctl.col_odd ? pair_ff + PAIR_W'(sample) : PAIR_W'(sample);

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_ff <= '0;
      end else if (ctl.restart) begin
         pair_ff <= '0;
      end else if (ctl.take) begin
         pair_ff <= pair_in;
      end
   end

   // Row parity keeps the write and the read in different cycles
   always_ff @(posedge clock) begin
      if (ctl.take && ctl.col_odd && !ctl.row_odd) begin
         line_mem[ctl.slot] <= pair_in;
      end
      if (ctl.take && ctl.col_odd && ctl.row_odd) begin
         above_ff <= line_mem[ctl.slot];
         below_ff <= pair_in;
      end
   end

   assign total = SUM_W'(above_ff) + SUM_W'(below_ff) + SUM_W'(2);

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         avg_ff <= total[c420ds_pkg::SAMPLE_W+1:2];
      end
   end

   assign average = avg_ff;

endmodule

// ===== rtl/chroma_420_downsampler.sv =====
// 4:2:0 chroma downsampler. One Cb/Cr pair is taken per request in raster order over an
// image of width_blocks*16 by height_blocks*16 positions; each odd column of each odd row
// yields one response with the rounded 2x2 means, tlast on the last response of an output
// row and tuser on the last of the frame. The block takes one request per clock cycle
// when the response side keeps up; the request that completes a 2x2 block loads
// stage 1, whose rounded means move on to the output register. A Cb lane and a Cr lane
// run side by side, each with a 1024 x 9 line store that is written on even rows and
// read on odd rows, so its single port is never asked for both in one cycle. Writing
// either size register restarts the frame at the top left corner; write only while idle.
module chroma_420_downsampler (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [15:0]                         req_tdata,   // cb_sample, cr_sample
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [15:0]                         rsp_tdata,   // cb_average, cr_average
   output logic                                rsp_tlast,   // last_in_row
   output logic                                rsp_tuser,   // last_in_frame
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [c420ds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [c420ds_pkg::BLK_W-1:0]        csr_data
);

   c420ds_pkg::pos_type      pos;
   c420ds_pkg::lane_ctl_type ctl;

   logic take, emit, load, out_free, csr_wr;
   logic s1_vld_ff, s1_vld_in;
   logic s1_row_ff, s1_frame_ff;
   logic out_vld_ff, out_vld_in;
   logic out_row_ff, out_frame_ff;
   logic [c420ds_pkg::SAMPLE_W-1:0] cb_avg, cr_avg;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   assign out_free   = !out_vld_ff || rsp_tready;
   assign load       = s1_vld_ff && out_free;
   assign req_tready = !s1_vld_ff || out_free;
   assign take       = req_tvalid && req_tready;
   assign emit       = take && pos.col_odd && pos.row_odd;

   assign s1_vld_in  = emit ? 1'b1 : (load ? 1'b0 : s1_vld_ff);
   assign out_vld_in = load ? 1'b1 : (rsp_tready ? 1'b0 : out_vld_ff);

   c420ds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .csr_wr    (csr_wr),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pos       (pos)
   );

   assign ctl.take    = take;
   assign ctl.col_odd = pos.col_odd;
   assign ctl.row_odd = pos.row_odd;
   assign ctl.slot    = pos.slot;
   assign ctl.load    = load;
   // writes to unused indexes leave the frame running
   assign ctl.restart = csr_wr && (csr_index == c420ds_pkg::CSR_WIDTH ||
                                   csr_index == c420ds_pkg::CSR_HEIGHT);

   c420ds_lane u_cb_lane (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .sample  (req_tdata[7:0]),
      .average (cb_avg)
   );

   c420ds_lane u_cr_lane (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl),
      .sample  (req_tdata[15:8]),
      .average (cr_avg)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         s1_row_ff   <= pos.row_end;
         s1_frame_ff <= pos.frame_end;
      end
      if (load) begin
         out_row_ff   <= s1_row_ff;
         out_frame_ff <= s1_frame_ff;
      end
   end

   // Merge the two lanes into one response
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {cr_avg, cb_avg};
   assign rsp_tlast  = out_row_ff;
   assign rsp_tuser  = out_frame_ff;

endmodule

// ===== rtl/c420ds_checker.sv =====
module c420ds_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser
);

   // Stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // Frame end is always also a row end
   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("frame end without row end");

   // Pipeline is empty right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind chroma_420_downsampler c420ds_checker u_c420ds_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

// ===== dv/tb_chroma_420_downsampler.sv =====
`timescale 1ns / 100ps

module tb_chroma_420_downsampler;

   localparam int IDX_W      = c420ds_pkg::CSR_IDX_W;
   localparam int BLK_W      = c420ds_pkg::BLK_W;
   localparam int LINE_DEPTH = c420ds_pkg::LINE_DEPTH;
   localparam int SLOT_W     = c420ds_pkg::SLOT_W;
   localparam int MAX_WIDTH  = c420ds_pkg::MAX_WIDTH;
   localparam int MAX_HEIGHT = c420ds_pkg::MAX_HEIGHT;

   localparam int SETTLE_CYCLES   = 8;
   localparam int RANDOM_ITEMS    = 200;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int MAX_REPORTS     = 10;
   localparam logic [IDX_W-1:0] TOP_CSR_INDEX = '1;

   // First two rows of a 16 wide frame, {cr, cb} per position in raster order.
   // Blocks: cb max / cr min, the reverse, near-max and near-min sums, half-way
   // rounding, alternating bit patterns, mid-scale, checkerboard, one-hot bits.
   localparam logic [0:31][15:0] OPENING_ROWS = {
      16'h00FF, 16'h00FF, 16'hFF00, 16'hFF00, 16'h00FF, 16'h00FF, 16'h0101, 16'h0001,
      16'hAA55, 16'h55AA, 16'h0280, 16'h017F, 16'h00FF, 16'hFF00, 16'h1001, 16'h2002,
      16'h00FF, 16'h00FF, 16'hFF00, 16'hFF00, 16'h00FF, 16'h01FE, 16'h0000, 16'h0000,
      16'h55AA, 16'hAA55, 16'h0080, 16'h007F, 16'h00FF, 16'hFF00, 16'h4004, 16'h8008};

   typedef struct packed {
      logic [7:0] cb_avg;
      logic [7:0] cr_avg;
      logic       row_last;
      logic       frame_last;
   } average_type;

   class chroma_scoreboard;
      logic [BLK_W-1:0] width_blocks;
      logic [BLK_W-1:0] height_blocks;
      logic [10:0]      column;
      logic [10:0]      row;
      logic [8:0]       cb_pair;
      logic [8:0]       cr_pair;
      logic [17:0]      line_sums [LINE_DEPTH];
      average_type      expected_averages [$];
      int               errors;

      function new();
         width_blocks = 8'd1;
         height_blocks = 8'd1;
         errors = 0;
         restart_frame();
      endfunction

      function void restart_frame();
         column = '0;
         row = '0;
         cb_pair = '0;
         cr_pair = '0;
      endfunction

      // zero counts as one block, oversize clamps to the largest multiple of 16
      function int span_of(logic [BLK_W-1:0] blocks, int limit);
         int span;
         span = ((blocks == 0) ? 1 : int'(blocks)) * 16;
         if (span > (limit / 16) * 16)
            span = (limit / 16) * 16;
         return span;
      endfunction

      function int frame_items();
         return span_of(width_blocks, MAX_WIDTH) * span_of(height_blocks, MAX_HEIGHT);
      endfunction

      function void write_reg(logic [IDX_W-1:0] reg_index, logic [BLK_W-1:0] value);
         if (reg_index == c420ds_pkg::CSR_WIDTH) begin
            width_blocks = value;
            restart_frame();
         end else if (reg_index == c420ds_pkg::CSR_HEIGHT) begin
            height_blocks = value;
            restart_frame();
         end
      endfunction

      function void note_sample(logic [7:0] cb, logic [7:0] cr);
         int                width;
         int                height;
         logic [SLOT_W-1:0] slot;
         logic              row_end;
         logic              frame_end;
         logic [9:0]        cb_total;
         logic [9:0]        cr_total;
         average_type       avg;
         width = span_of(width_blocks, MAX_WIDTH);
         height = span_of(height_blocks, MAX_HEIGHT);
         slot = column[10:1];
         row_end = (int'(column) + 1 >= width);
         frame_end = row_end && (int'(row) + 1 >= height);
         if (!column[0]) begin
            cb_pair = cb;
            cr_pair = cr;
         end else begin
            cb_pair = cb_pair + cb;
            cr_pair = cr_pair + cr;
            if (!row[0]) begin
               line_sums[slot] = {cr_pair, cb_pair};
            end else begin
               cb_total = cb_pair + line_sums[slot][8:0];
               cr_total = cr_pair + line_sums[slot][17:9];
               avg.cb_avg = 8'((cb_total + 10'd2) >> 2);
               avg.cr_avg = 8'((cr_total + 10'd2) >> 2);
               avg.row_last = row_end;
               avg.frame_last = frame_end;
               expected_averages.push_back(avg);
            end
         end
         if (frame_end) begin
            column = '0;
            row = '0;
         end else if (row_end) begin
            column = '0;
            row = row + 1'b1;
         end else begin
            column = column + 1'b1;
         end
      endfunction

      function void check_average(logic [7:0] cb, logic [7:0] cr, logic row_last,
                                  logic frame_last);
         average_type want;
         if (expected_averages.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: unexpected response cb=%0d cr=%0d tlast=%b tuser=%b",
                        $time, cb, cr, row_last, frame_last);
            return;
         end
         want = expected_averages.pop_front();
         if (cb !== want.cb_avg || cr !== want.cr_avg || row_last !== want.row_last ||
             frame_last !== want.frame_last) begin
            errors++;
            if (errors <= MAX_REPORTS)
               $display("%0t: exp cb=%0d cr=%0d last=%b/%b, got cb=%0d cr=%0d last=%b/%b",
                        $time, want.cb_avg, want.cr_avg, want.row_last, want.frame_last,
                        cb, cr, row_last, frame_last);
         end
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [15:0]          req_tdata = '0;    // cb_sample, cr_sample
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [15:0]          rsp_tdata;         // cb_average, cr_average
   logic                 rsp_tlast;         // last_in_row
   logic                 rsp_tuser;         // last_in_frame
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [IDX_W-1:0]     csr_index = '0;
   logic [BLK_W-1:0]     csr_data = '0;

   chroma_scoreboard sb;
   logic quiet = 1'b0;
   int   quiet_left = 0;
   int   stall_left = 0;
   int   idle_cycles = 0;

   chroma_420_downsampler DUT (.*);

   always #2 clock = ~clock;

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] random_sample();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // stretches with no idling on either side
   always @(posedge clock) begin
      if (quiet_left == 0) begin
         quiet <= ($urandom_range(0, 3) == 0);
         quiet_left <= $urandom_range(50, 300);
      end else begin
         quiet_left <= quiet_left - 1;
      end
   end

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= gap_length() - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_average(rsp_tdata[7:0], rsp_tdata[15:8], rsp_tlast, rsp_tuser);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || (csr_valid && csr_ready))
      begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic drain_averages();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_averages.size() != 0)
         @(posedge clock);
   endtask

   task automatic send_sample(input logic [7:0] cb, input logic [7:0] cr);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? gap_length() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {cr, cb};
      do @(posedge clock); while (!req_tready);
      sb.note_sample(cb, cr);
      // occasionally hold the next request until every average is out
      if ($urandom_range(0, 199) == 0)
         drain_averages();
   endtask

   task automatic run_items(input int count);
      repeat (count) send_sample(random_sample(), random_sample());
   endtask

   task automatic wait_idle();
      drain_averages();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [IDX_W-1:0] reg_index,
                            input logic [BLK_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(reg_index, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      int random_count;
      int n;
      int frame;
      sb = new();
      random_count = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset sizes: hand-picked blocks on the first output row, then the rest of the frame
      for (int i = 0; i < 32; i++)
         send_sample(OPENING_ROWS[i][7:0], OPENING_ROWS[i][15:8]);
      run_items(16 * 16 - 32);
      wait_idle();

      // zero block counts; stop halfway through a pair on an even row
      write_csr(c420ds_pkg::CSR_WIDTH, 8'd0);
      write_csr(c420ds_pkg::CSR_HEIGHT, 8'd0);
      run_items(2 * 16 + 9);
      wait_idle();

      // unused indexes: no restart, pair sum and raster position carry on
      write_csr(c420ds_pkg::CSR_HEIGHT + 1'b1, 8'hFF);
      write_csr(TOP_CSR_INDEX, 8'h00);
      run_items(16 + 7);
      wait_idle();

      // largest in-range counts, then restart mid-frame
      write_csr(c420ds_pkg::CSR_HEIGHT, 8'd128);
      write_csr(c420ds_pkg::CSR_WIDTH, 8'd128);
      run_items(40);
      wait_idle();
      write_csr(c420ds_pkg::CSR_WIDTH, 8'd1);
      write_csr(c420ds_pkg::CSR_HEIGHT, 8'd1);
      run_items(16 * 3 + 7);
      wait_idle();
      write_csr(c420ds_pkg::CSR_WIDTH, 8'd1);
      run_items(40);
      wait_idle();

      while (random_count < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: write_csr(IDX_W'($urandom_range(int'(c420ds_pkg::CSR_HEIGHT) + 1,
                                               int'(TOP_CSR_INDEX))),
                         BLK_W'($urandom));
            1: write_csr(c420ds_pkg::CSR_WIDTH, BLK_W'($urandom_range(0, 2)));
            2: write_csr(c420ds_pkg::CSR_HEIGHT, BLK_W'($urandom_range(0, 1)));
            default: begin
               write_csr(c420ds_pkg::CSR_HEIGHT, BLK_W'($urandom_range(0, 1)));
               write_csr(c420ds_pkg::CSR_WIDTH, BLK_W'($urandom_range(0, 2)));
            end
         endcase
         frame = sb.frame_items();
         if ($urandom_range(0, 2) == 0)
            n = $urandom_range(1, 64);
         else
            n = $urandom_range(frame / 2, frame + frame / 2);
         if (n > RANDOM_ITEMS - random_count)
            n = RANDOM_ITEMS - random_count;
         run_items(n);
         random_count += n;
         wait_idle();
      end

      if (sb.errors == 0 && sb.expected_averages.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
